@@ hdl/gn3d_pkg.sv @@
package gn3d_pkg;

  localparam int TableSize = 256;
  localparam int FracBitsDefault = 16;
  localparam int FixIntBits = 5;
  localparam int CoordWidth = 24;
  localparam int NoiseWidth = 18;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdEval = 1'b1;

endpackage

@@ hdl/gradient_noise_3d.sv @@
// channel | direction | signals
// in      | to block  | in_valid_i, in_stall_o, command_i, table_index_i, table_value_i, coord_*_i
// out     | from block| out_valid_o, out_stall_i, noise_value_o
// one word enters per cycle while out_stall_i is low; out_stall_i holds the whole pipeline
// the pipeline has fade and hash paths; each lerp level takes two stages
// a write word updates every table copy, no result
// rst_ni clears all valid bits; table contents stay undefined until written
// out_stall_i freezes the whole pipeline; in_stall_o follows it
module gradient_noise_3d #(
  parameter int FracBits = gn3d_pkg::FracBitsDefault
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   command_i,
  input  logic [7:0]                             table_index_i,
  input  logic [7:0]                             table_value_i,
  input  logic [gn3d_pkg::CoordWidth-1:0]        coord_x_i,
  input  logic [gn3d_pkg::CoordWidth-1:0]        coord_y_i,
  input  logic [gn3d_pkg::CoordWidth-1:0]        coord_z_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [gn3d_pkg::NoiseWidth-1:0] noise_value_o
);

  localparam int W = FracBits + gn3d_pkg::FixIntBits;
  localparam int NS = 16;
  localparam logic signed [W-1:0] One = W'(1) << FracBits;

  typedef logic signed [W-1:0] fx_t;

  logic adv;
  assign adv = !out_stall_i;
  assign in_stall_o = out_stall_i;

  logic accept;
  assign accept = in_valid_i && !out_stall_i;
  logic wr_en;
  assign wr_en = accept && (command_i == gn3d_pkg::CmdWrite);

  logic [NS-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NS-2:0], accept && (command_i == gn3d_pkg::CmdEval)};
    end
  end

  function automatic fx_t frac_f(logic [15:0] c);
    logic [W+15:0] e;
    begin
      e = (W+16)'(c) << FracBits;
      frac_f = W'(e >> 16);
    end
  endfunction

  // stage arrays
  fx_t x_q [NS];
  fx_t y_q [NS];
  fx_t z_q [NS];
  logic [7:0] xi_q [NS];
  logic [7:0] yi_q [NS];
  logic [7:0] zi_q [NS];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q[0] <= frac_f(coord_x_i[15:0]);
      y_q[0] <= frac_f(coord_y_i[15:0]);
      z_q[0] <= frac_f(coord_z_i[15:0]);
      xi_q[0] <= coord_x_i[23:16];
      yi_q[0] <= coord_y_i[23:16];
      zi_q[0] <= coord_z_i[23:16];
      for (int i = 1; i < NS; i++) begin
        x_q[i] <= x_q[i-1];
        y_q[i] <= y_q[i-1];
        z_q[i] <= z_q[i-1];
        xi_q[i] <= xi_q[i-1];
        yi_q[i] <= yi_q[i-1];
        zi_q[i] <= zi_q[i-1];
      end
    end
  end

  // fade: five product stages per axis, stages 1..5
  fx_t fr_q [3][5];
  fx_t fin [3][5];
  fx_t fmo [3][5];
  fx_t ft [3][5];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ft[a][0] = (a == 0) ? x_q[0] : (a == 1) ? y_q[0] : z_q[0];
      for (int s = 1; s < 5; s++) begin
        ft[a][s] = (a == 0) ? x_q[s] : (a == 1) ? y_q[s] : z_q[s];
      end
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_fade
    for (genvar s = 1; s < 5; s++) begin : g_m
      gn3d_mulq #(.FracBits(FracBits)) u_m (
        .a_i(ft[a][s]), .b_i(fr_q[a][s-1]), .p_o(fmo[a][s])
      );
    end
    assign fin[a][0] = fr_q[a][0];
    assign fin[a][1] = fr_q[a][1];
    assign fin[a][2] = fr_q[a][2];
    assign fin[a][3] = fr_q[a][3];
    assign fin[a][4] = fr_q[a][4];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        fr_q[a][0] <= W'(6) * ft[a][0] - W'(15) * One;
        fr_q[a][1] <= fmo[a][1] + W'(10) * One;
        fr_q[a][2] <= fmo[a][2];
        fr_q[a][3] <= fmo[a][3];
        fr_q[a][4] <= fmo[a][4];
      end
    end
  end

  // fade values delay line, u_q[i] travels with stage i+1
  fx_t u_q [NS];
  fx_t v_q [NS];
  fx_t w_q [NS];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      u_q[5] <= fin[0][4];
      v_q[5] <= fin[1][4];
      w_q[5] <= fin[2][4];
      for (int i = 6; i < NS; i++) begin
        u_q[i] <= u_q[i-1];
        v_q[i] <= v_q[i-1];
        w_q[i] <= w_q[i-1];
      end
    end
  end

  // hash: replicated tables, write goes to every copy
  // level 1: P(X), P(X+1) read from the input word -> data at stage 0
  logic [7:0] p1 [2];
  logic [7:0] p2 [4];
  logic [7:0] p3 [8];
  logic [7:0] r1a [2];
  logic [7:0] r2a [4];
  logic [7:0] r3a [8];

  assign r1a[0] = xi_q[0];
  assign r1a[1] = xi_q[0] + 8'd1;

  // wait: addresses must use the live stage; read at stage k uses stage k-1 data
  logic [7:0] a1 [2];
  assign a1[0] = coord_x_i[23:16];
  assign a1[1] = coord_x_i[23:16] + 8'd1;

  for (genvar i = 0; i < 2; i++) begin : g_l1
    gn3d_perm_mem u_mem (
      .clk_i, .we_i(wr_en), .waddr_i(table_index_i), .wdata_i(table_value_i),
      .re_i(adv), .raddr_i(a1[i]), .rdata_o(p1[i])
    );
  end

  // p1 valid at stage 0 outputs (aligned with xi_q[0])
  logic [7:0] ab [2];
  assign ab[0] = p1[0] + yi_q[0];
  assign ab[1] = p1[1] + yi_q[0];
  assign r2a[0] = ab[0];
  assign r2a[1] = ab[0] + 8'd1;
  assign r2a[2] = ab[1];
  assign r2a[3] = ab[1] + 8'd1;

  for (genvar i = 0; i < 4; i++) begin : g_l2
    gn3d_perm_mem u_mem (
      .clk_i, .we_i(wr_en), .waddr_i(table_index_i), .wdata_i(table_value_i),
      .re_i(adv), .raddr_i(r2a[i]), .rdata_o(p2[i])
    );
  end

  // p2 aligned with stage 1: AA,AB,BA,BB indices
  logic [7:0] cz [4];
  for (genvar i = 0; i < 4; i++) begin : g_cz
    assign cz[i] = p2[i] + zi_q[1];
    assign r3a[2*i]   = cz[i];
    assign r3a[2*i+1] = cz[i] + 8'd1;
  end

  // level 3 copies take a write through the wr_l3_q register to keep word order
  logic       wr_l3_q;
  logic [7:0] wr_idx_l3_q;
  logic [7:0] wr_val_l3_q;
  logic       we_l3;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_l3_q <= 1'b0;
    end else if (adv) begin
      wr_l3_q <= wr_en;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      wr_idx_l3_q <= table_index_i;
      wr_val_l3_q <= table_value_i;
    end
  end
  assign we_l3 = wr_l3_q && adv;

  for (genvar i = 0; i < 8; i++) begin : g_l3
    gn3d_perm_mem u_mem (
      .clk_i, .we_i(we_l3), .waddr_i(wr_idx_l3_q), .wdata_i(wr_val_l3_q),
      .re_i(adv), .raddr_i(r3a[i]), .rdata_o(p3[i])
    );
  end

  // p3 aligned with stage 2. order: AA,AA+1,AB,AB+1,BA,BA+1,BB,BB+1
  logic [3:0] h_q [8][3:NS-1];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 8; i++) begin
        h_q[i][3] <= p3[i][3:0];
        for (int s = 4; s < NS; s++) begin
          h_q[i][s] <= h_q[i][s-1];
        end
      end
    end
  end

  function automatic fx_t grad_f(logic [3:0] h, fx_t gx, fx_t gy, fx_t gz);
    fx_t gu;
    fx_t gv;
    begin
      gu = (h < 4'd8) ? gx : gy;
      gv = (h < 4'd4) ? gy : ((h == 4'd12 || h == 4'd14) ? gx : gz);
      grad_f = (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
    end
  endfunction

  // gradients at stage 5 into stage 6 registers; corner bits (dx,dy,dz)
  fx_t g_q [8];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 8; c++) begin
        // c = {dx,dy,dz}; table order index = dx*4 + dy*2 + dz
        g_q[c] <= grad_f(h_q[c][5],
                         c[2] ? x_q[5] - One : x_q[5],
                         c[1] ? y_q[5] - One : y_q[5],
                         c[0] ? z_q[5] - One : z_q[5]);
      end
    end
  end

  // lerp level 1 (u): stage 7 mult, stage 8 add
  fx_t d1_q [4];
  fx_t a1_q [4];
  fx_t m1 [4];
  fx_t l1_q [4];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        d1_q[k] <= g_q[4+k] - g_q[k];
        a1_q[k] <= g_q[k];
      end
    end
  end
  for (genvar k = 0; k < 4; k++) begin : g_m1
    gn3d_mulq #(.FracBits(FracBits)) u_m (.a_i(u_q[6]), .b_i(d1_q[k]), .p_o(m1[k]));
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) l1_q[k] <= a1_q[k] + m1[k];
    end
  end

  // level 2 (v): l1 index = dy*2+dz
  fx_t d2_q [2];
  fx_t a2_q [2];
  fx_t m2 [2];
  fx_t l2_q [2];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 2; k++) begin
        d2_q[k] <= l1_q[2+k] - l1_q[k];
        a2_q[k] <= l1_q[k];
      end
    end
  end
  for (genvar k = 0; k < 2; k++) begin : g_m2
    gn3d_mulq #(.FracBits(FracBits)) u_m (.a_i(v_q[8]), .b_i(d2_q[k]), .p_o(m2[k]));
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 2; k++) l2_q[k] <= a2_q[k] + m2[k];
    end
  end

  // level 3 (w)
  fx_t d3_q;
  fx_t a3_q;
  fx_t m3;
  fx_t l3_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      d3_q <= l2_q[1] - l2_q[0];
      a3_q <= l2_q[0];
    end
  end
  gn3d_mulq #(.FracBits(FracBits)) u_m3 (.a_i(w_q[10]), .b_i(d3_q), .p_o(m3));
  always_ff @(posedge clk_i) begin
    if (adv) l3_q <= a3_q + m3;
  end

  // scale to Q2.16 and saturate
  localparam int SW = W + 17;
  logic signed [SW-1:0] sc;
  always_comb begin
    if (FracBits > 16) begin
      sc = (SW'(l3_q) + (SW'(1) <<< (FracBits - 17))) >>> (FracBits - 16);
    end else begin
      sc = SW'(l3_q) <<< (16 - FracBits);
    end
  end

  logic signed [gn3d_pkg::NoiseWidth-1:0] res_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (sc > SW'(131071)) res_q <= 18'sd131071;
      else if (sc < -SW'(131072)) res_q <= -18'sd131072;
      else res_q <= sc[gn3d_pkg::NoiseWidth-1:0];
    end
  end

  assign out_valid_o = vld_q[13];
  assign noise_value_o = res_q;

  logic unused;
  assign unused = ^{vld_q[NS-1:14], r1a[0], r1a[1], fin[0][0], fin[1][0], fin[2][0],
                    u_q[NS-1], v_q[NS-1], w_q[NS-1], xi_q[NS-1], yi_q[NS-1], zi_q[NS-1]};

endmodule

@@ hdl/gn3d_perm_mem.sv @@
module gn3d_perm_mem (
  input  logic       clk_i,
  input  logic       we_i,
  input  logic [7:0] waddr_i,
  input  logic [7:0] wdata_i,
  input  logic       re_i,
  input  logic [7:0] raddr_i,
  output logic [7:0] rdata_o
);

  logic [7:0] mem_q [gn3d_pkg::TableSize];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ hdl/gn3d_mulq.sv @@
module gn3d_mulq #(
  parameter int FracBits = gn3d_pkg::FracBitsDefault
) (
  input  logic signed [FracBits+gn3d_pkg::FixIntBits-1:0] a_i,
  input  logic signed [FracBits+gn3d_pkg::FixIntBits-1:0] b_i,
  output logic signed [FracBits+gn3d_pkg::FixIntBits-1:0] p_o
);

  localparam int W = FracBits + gn3d_pkg::FixIntBits;

  logic signed [2*W-1:0] prod;
  logic signed [2*W-1:0] rnd;

  always_comb begin
    prod = a_i * b_i;
    rnd  = prod + (2*W)'(signed'(1) <<< (FracBits - 1));
    p_o  = W'(rnd >>> FracBits);
  end

endmodule

@@ tb/gradient_noise_3d_checker.sv @@
module gradient_noise_3d_checker #(
  parameter int FracBits = gn3d_pkg::FracBitsDefault
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  input  logic                                   in_stall_i,
  input  logic                                   command_i,
  input  logic [7:0]                             table_index_i,
  input  logic [7:0]                             table_value_i,
  input  logic [gn3d_pkg::CoordWidth-1:0]        coord_x_i,
  input  logic [gn3d_pkg::CoordWidth-1:0]        coord_y_i,
  input  logic [gn3d_pkg::CoordWidth-1:0]        coord_z_i,
  input  logic                                   out_valid_i,
  input  logic                                   out_stall_i,
  input  logic signed [gn3d_pkg::NoiseWidth-1:0] noise_value_i,
  output int                                     fail_count_o,
  output int                                     pending_o
);

  logic [7:0] perm_q [gn3d_pkg::TableSize];
  logic signed [gn3d_pkg::NoiseWidth-1:0] noise_fifo [$];

  function automatic longint rshift_floor(longint p, int s);
    if (s == 0) return p;
    return p >>> s;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return rshift_floor(a * b + (longint'(1) <<< (FracBits - 1)), FracBits);
  endfunction

  function automatic longint fade_curve(longint t);
    longint one, r;
    one = longint'(1) <<< FracBits;
    r = 6 * t - 15 * one;
    r = qmul(t, r) + 10 * one;
    r = qmul(t, r);
    r = qmul(t, r);
    return qmul(t, r);
  endfunction

  function automatic longint blend(longint t, longint a, longint b);
    return a + qmul(t, b - a);
  endfunction

  function automatic longint corner_grad(logic [7:0] hv, longint x, longint y, longint z);
    logic [3:0] h;
    longint u, v;
    h = hv[3:0];
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic longint coord_frac(logic [gn3d_pkg::CoordWidth-1:0] c);
    longint f;
    f = longint'(c[15:0]);
    if (FracBits >= 16) return f <<< (FracBits - 16);
    return f >>> (16 - FracBits);
  endfunction

  function automatic logic [7:0] pt(int i);
    return perm_q[i & 255];
  endfunction

  function automatic logic signed [gn3d_pkg::NoiseWidth-1:0] noise_at(
      logic [gn3d_pkg::CoordWidth-1:0] cx, logic [gn3d_pkg::CoordWidth-1:0] cy,
      logic [gn3d_pkg::CoordWidth-1:0] cz);
    longint one, x, y, z, x1, y1, z1, u, v, w, r;
    int xi, yi, zi, a, b, aa, ab, ba, bb;
    one = longint'(1) <<< FracBits;
    xi = int'(cx[23:16]);
    yi = int'(cy[23:16]);
    zi = int'(cz[23:16]);
    x = coord_frac(cx);
    y = coord_frac(cy);
    z = coord_frac(cz);
    x1 = x - one;
    y1 = y - one;
    z1 = z - one;
    u = fade_curve(x);
    v = fade_curve(y);
    w = fade_curve(z);
    a = pt(xi) + yi;
    aa = pt(a) + zi;
    ab = pt(a + 1) + zi;
    b = pt(xi + 1) + yi;
    ba = pt(b) + zi;
    bb = pt(b + 1) + zi;
    r = blend(w,
      blend(v,
        blend(u, corner_grad(pt(aa), x, y, z), corner_grad(pt(ba), x1, y, z)),
        blend(u, corner_grad(pt(ab), x, y1, z), corner_grad(pt(bb), x1, y1, z))),
      blend(v,
        blend(u, corner_grad(pt(aa + 1), x, y, z1), corner_grad(pt(ba + 1), x1, y, z1)),
        blend(u, corner_grad(pt(ab + 1), x, y1, z1), corner_grad(pt(bb + 1), x1, y1, z1))));
    if (FracBits > 16) r = rshift_floor(r + (longint'(1) <<< (FracBits - 17)), FracBits - 16);
    else r = r <<< (16 - FracBits);
    if (r > 131071) r = 131071;
    if (r < -131072) r = -131072;
    return r[gn3d_pkg::NoiseWidth-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [gn3d_pkg::NoiseWidth-1:0] want;
    if (!rst_ni) begin
      fail_count_o <= 0;
      pending_o <= 0;
      noise_fifo.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        if (command_i == gn3d_pkg::CmdWrite) begin
          perm_q[table_index_i] = table_value_i;
        end else begin
          noise_fifo.push_back(noise_at(coord_x_i, coord_y_i, coord_z_i));
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (noise_fifo.size() == 0) begin
          if (fail_count_o < 10) $display("unexpected word noise=%0d", noise_value_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = noise_fifo.pop_front();
          if (want !== noise_value_i) begin
            if (fail_count_o < 10)
              $display("noise mismatch exp=%0d got=%0d", want, noise_value_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      pending_o <= noise_fifo.size();
    end
  end

endmodule

@@ tb/tb_gradient_noise_3d.sv @@
module tb_gradient_noise_3d;

  localparam int WatchdogLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic command_i = gn3d_pkg::CmdWrite;
  logic [7:0] table_index_i = '0;
  logic [7:0] table_value_i = '0;
  logic [gn3d_pkg::CoordWidth-1:0] coord_x_i = '0;
  logic [gn3d_pkg::CoordWidth-1:0] coord_y_i = '0;
  logic [gn3d_pkg::CoordWidth-1:0] coord_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [gn3d_pkg::NoiseWidth-1:0] noise_value_o;
  int fail_count, pending, quiet_cycles;
  bit calm;

  always #5 clk_i = ~clk_i;

  gradient_noise_3d uut (.*);

  gradient_noise_3d_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .command_i, .table_index_i,
    .table_value_i, .coord_x_i, .coord_y_i, .coord_z_i, .out_valid_i(out_valid_o),
    .out_stall_i, .noise_value_i(noise_value_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    out_stall_i <= !calm && rst_ni && ($urandom_range(99) < 11);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("gradient_noise_3d verification failed");
      $finish;
    end
  end

  task automatic send_word(logic cmd, logic [7:0] idx, logic [7:0] val,
                           logic [gn3d_pkg::CoordWidth-1:0] x,
                           logic [gn3d_pkg::CoordWidth-1:0] y,
                           logic [gn3d_pkg::CoordWidth-1:0] z);
    while (!calm && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    table_index_i <= idx;
    table_value_i <= val;
    coord_x_i <= x;
    coord_y_i <= y;
    coord_z_i <= z;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic eval_point(logic [gn3d_pkg::CoordWidth-1:0] x,
                            logic [gn3d_pkg::CoordWidth-1:0] y,
                            logic [gn3d_pkg::CoordWidth-1:0] z);
    send_word(gn3d_pkg::CmdEval, 8'($urandom), 8'($urandom), x, y, z);
  endtask

  initial begin
    calm = 1'b0;
    quiet_cycles = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // fill the whole table before any lookup, identity but entry 0 holds 8'hff, then extremes
    for (int i = 0; i < gn3d_pkg::TableSize; i++) begin
      send_word(gn3d_pkg::CmdWrite, i[7:0], (i == 0) ? 8'hff : i[7:0],
                gn3d_pkg::CoordWidth'($urandom), gn3d_pkg::CoordWidth'($urandom),
                gn3d_pkg::CoordWidth'($urandom));
    end
    eval_point('0, '0, '0);
    eval_point('1, '1, '1);
    eval_point(24'h00ffff, 24'h000000, 24'hff8000);
    eval_point(24'h018000, 24'h028000, 24'h038000);
    eval_point(24'hff0001, 24'h7fffff, 24'h800000);
    eval_point(24'h00aaaa, 24'h005555, 24'h00ffff);
    for (int h = 0; h < 16; h++) begin
      send_word(gn3d_pkg::CmdWrite, 8'd0, 8'(h), '0, '0, '0);
      eval_point(24'h004000, 24'h00c000, 24'h008000);
    end
    for (int n = 0; n < 300; n++) begin
      calm = (n >= 100 && n < 200);
      if ($urandom_range(9) == 0) send_word(gn3d_pkg::CmdWrite, 8'($urandom), 8'($urandom),
                                            gn3d_pkg::CoordWidth'($urandom),
                                            gn3d_pkg::CoordWidth'($urandom),
                                            gn3d_pkg::CoordWidth'($urandom));
      else eval_point(gn3d_pkg::CoordWidth'($urandom), gn3d_pkg::CoordWidth'($urandom),
                      gn3d_pkg::CoordWidth'($urandom));
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) $display("gradient_noise_3d verification clean");
    else $display("gradient_noise_3d verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/gn3d_pkg.sv
hdl/gn3d_perm_mem.sv
hdl/gn3d_mulq.sv
hdl/gradient_noise_3d.sv
tb/gradient_noise_3d_checker.sv
tb/tb_gradient_noise_3d.sv
